/* sv/v3a_pkg.sv */
// v3a_pkg: shared types, opcodes and saturation helper for the vector ALU.
// No dependencies; every other file but v3a_if imports it.
`timescale 1ns / 1ps

package v3a_pkg;

    localparam int WORD_W = 32;
    localparam int SAT_W  = 80;
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 34;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_MAG   = 4'd7,
        OP_NORM  = 4'd8
    } op_t;

    typedef struct packed {
        logic [3:0]               op;
        logic signed [WORD_W-1:0] ax;
        logic signed [WORD_W-1:0] ay;
        logic signed [WORD_W-1:0] az;
        logic signed [WORD_W-1:0] bx;
        logic signed [WORD_W-1:0] by_comp;
        logic signed [WORD_W-1:0] bz;
        logic signed [WORD_W-1:0] k;
    } item_t;

    // results known early travel alongside the sqrt and divide pipes
    typedef struct packed {
        logic [3:0]               op;
        logic signed [WORD_W-1:0] rx;
        logic signed [WORD_W-1:0] ry;
        logic signed [WORD_W-1:0] rz;
        logic                     sat;
        logic signed [WORD_W-1:0] ax;
        logic signed [WORD_W-1:0] ay;
        logic signed [WORD_W-1:0] az;
        logic signed [WORD_W-1:0] k;
    } side_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] val;
        logic                     sat;
    } satw_t;

    function automatic satw_t sat_word(input logic signed [SAT_W-1:0] v);
        satw_t r;
        if (v > SAT_W'(WORD_MAX))
        begin
            r.val = WORD_MAX;
            r.sat = 1'b1;
        end
        else if (v < SAT_W'(WORD_MIN))
        begin
            r.val = WORD_MIN;
            r.sat = 1'b1;
        end
        else
        begin
            r.val = v[WORD_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

/* sv/v3a_if.sv */
// v3a_in_if / v3a_out_if: valid/ready channels for operand and result words.
// No dependencies.
`timescale 1ns / 1ps

interface v3a_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by_comp;
    logic signed [31:0] bz;
    logic signed [31:0] scalar_k;

    modport source (output valid, op, ax, ay, az, bx, by_comp, bz, scalar_k, input ready);
    modport sink   (input valid, op, ax, ay, az, bx, by_comp, bz, scalar_k, output ready);
endinterface

interface v3a_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic               saturated;

    modport source (output valid, res_x, res_y, res_z, saturated, input ready);
    modport sink   (input valid, res_x, res_y, res_z, saturated, output ready);
endinterface

/* sv/vec3_arith_unit_top.sv */
// vec3_arith_unit_top: pipelined three-component Q-format vector ALU.
// Depends on v3a_pkg, v3a_if, v3a_mul_stage, v3a_sqrt_pipe, v3a_div_pipe.
//
//   channel  role    words                                      handshake
//   req      sink    op, ax..az, bx, by_comp, bz, scalar_k      valid/ready
//   rsp      source  res_x, res_y, res_z, saturated             valid/ready
//
// One word per cycle in and out while rsp is not stalled; every opcode takes the same
// path (multiply, combine, 32 root stages, two divide prep stages, 33 + FRAC_BITS
// quotient stages, output register).
// A stalled rsp freezes the whole pipe; req.ready drops only then.
// Reset clears the valid bits; no clearing pass.
`timescale 1ns / 1ps

module vec3_arith_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    v3a_in_if.sink    req,
    v3a_out_if.source rsp
);
    import v3a_pkg::*;

    localparam int NW  = FRAC_BITS + 33;     // numerator magnitude bits
    localparam int DW  = 34;                 // twice the divisor
    localparam int NS  = FRAC_BITS + 36;     // signed numerator work width
    localparam int CW  = 66;                 // sum of products
    localparam int GUARD_MAX = ((1 << FRAC_BITS) - 1) / 1000000;
    localparam logic signed [CW-1:0] HALF = CW'(1) <<< (FRAC_BITS - 1);
    localparam logic [32:0] ONE_D = 33'(1) << FRAC_BITS;

    logic en;

    // input
    item_t in_item;
    assign in_item = '{op: req.op, ax: req.ax, ay: req.ay, az: req.az, bx: req.bx,
                       by_comp: req.by_comp, bz: req.bz, k: req.scalar_k};

    // multiply stage
    logic               m_valid;
    item_t              m_item;
    logic signed [63:0] m_prod [6];

    v3a_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .in_item   (in_item),
        .out_valid (m_valid),
        .out_item  (m_item),
        .prod      (m_prod)
    );

    // combine stage: add/sub, rounded products, dot, cross, sum of squares
    logic signed [CW-1:0] c_r [3];
    side_t                c_side_next;
    logic [SQ_W-1:0]      c_sq_next;
    satw_t                c_sw [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            c_r[i] = '0;
        case (m_item.op)
            OP_ADD:
            begin
                c_r[0] = CW'(m_item.ax) + CW'(m_item.bx);
                c_r[1] = CW'(m_item.ay) + CW'(m_item.by_comp);
                c_r[2] = CW'(m_item.az) + CW'(m_item.bz);
            end
            OP_SUB:
            begin
                c_r[0] = CW'(m_item.ax) - CW'(m_item.bx);
                c_r[1] = CW'(m_item.ay) - CW'(m_item.by_comp);
                c_r[2] = CW'(m_item.az) - CW'(m_item.bz);
            end
            OP_MUL, OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    c_r[i] = (CW'(m_prod[i]) + HALF) >>> FRAC_BITS;
            end
            OP_DOT:
            begin
                c_r[0] = (CW'(m_prod[0]) + CW'(m_prod[1]) + CW'(m_prod[2]) + HALF)
                         >>> FRAC_BITS;
            end
            OP_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                    c_r[i] = (CW'(m_prod[i]) - CW'(m_prod[i+3]) + HALF) >>> FRAC_BITS;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < 3; i++)
            c_sw[i] = sat_word(SAT_W'(c_r[i]));
        c_side_next.op  = m_item.op;
        c_side_next.rx  = c_sw[0].val;
        c_side_next.ry  = c_sw[1].val;
        c_side_next.rz  = c_sw[2].val;
        c_side_next.sat = c_sw[0].sat | c_sw[1].sat | c_sw[2].sat;
        c_side_next.ax  = m_item.ax;
        c_side_next.ay  = m_item.ay;
        c_side_next.az  = m_item.az;
        c_side_next.k   = m_item.k;
        // squares are non-negative and their sum stays below 2^64
        c_sq_next = $unsigned(m_prod[0]) + $unsigned(m_prod[1]) + $unsigned(m_prod[2]);
    end

    logic            c_valid_reg;
    side_t           c_side_reg;
    logic [SQ_W-1:0] c_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= m_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg <= c_side_next;
            c_sq_reg   <= c_sq_next;
        end
    end

    // square root
    logic              q_valid;
    side_t             q_side;
    logic [ROOT_W-1:0] q_root;
    logic [REM_W-1:0]  q_rem;

    v3a_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_side   (c_side_reg),
        .in_rad    (c_sq_reg),
        .out_valid (q_valid),
        .out_side  (q_side),
        .out_root  (q_root),
        .out_rem   (q_rem)
    );

    // prep 1: round root, magnitude result, divisor select with guard
    logic [ROOT_W-1:0] p1_root;
    logic signed [32:0] p1_kx;
    logic [32:0]       p1_dsel;
    logic              p1_guard;
    satw_t             p1_msw;
    side_t             p1_side_next;
    logic [32:0]       p1_d_next;
    logic              p1_neg_next;

    always_comb
    begin
        p1_root = q_root + ROOT_W'(q_rem > REM_W'(q_root));
        p1_kx   = 33'(q_side.k);
        p1_msw  = sat_word(SAT_W'($signed({1'b0, p1_root})));
        if (q_side.op == OP_DIV)
            p1_dsel = p1_kx[32] ? $unsigned(-p1_kx) : $unsigned(p1_kx);
        else
            p1_dsel = 33'(p1_root);
        p1_guard     = (p1_dsel <= 33'(GUARD_MAX));
        p1_d_next    = p1_guard ? ONE_D : p1_dsel;
        p1_neg_next  = (q_side.op == OP_DIV) && q_side.k[WORD_W-1] && !p1_guard;
        p1_side_next = q_side;
        if (q_side.op == OP_MAG)
        begin
            p1_side_next.rx  = p1_msw.val;
            p1_side_next.ry  = '0;
            p1_side_next.rz  = '0;
            p1_side_next.sat = p1_msw.sat;
        end
    end

    logic        p1_valid_reg;
    side_t       p1_side_reg;
    logic [32:0] p1_d_reg;
    logic        p1_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (en)
            p1_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_side_reg <= p1_side_next;
            p1_d_reg    <= p1_d_next;
            p1_neg_reg  <= p1_neg_next;
        end
    end

    // prep 2: N = 2*(+/-a << F) + d, split into sign and magnitude
    logic signed [WORD_W-1:0] p2_a [3];
    logic signed [NS-1:0]     p2_two [3];
    logic signed [NS-1:0]     p2_n [3];
    logic signed [NS-1:0]     p2_dd;
    logic [NW-1:0]            p2_num_next [3];
    logic                     p2_nneg_next [3];

    always_comb
    begin
        p2_a[0] = p1_side_reg.ax;
        p2_a[1] = p1_side_reg.ay;
        p2_a[2] = p1_side_reg.az;
        p2_dd   = NS'($signed({1'b0, p1_d_reg}));
        for (int l = 0; l < 3; l++)
        begin
            p2_two[l]       = NS'(p2_a[l]) <<< (FRAC_BITS + 1);
            p2_n[l]         = p1_neg_reg ? (p2_dd - p2_two[l]) : (p2_dd + p2_two[l]);
            p2_nneg_next[l] = p2_n[l][NS-1];
            p2_num_next[l]  = p2_nneg_next[l] ? NW'(-p2_n[l]) : NW'(p2_n[l]);
        end
    end

    logic          p2_valid_reg;
    side_t         p2_side_reg;
    logic [DW-1:0] p2_den_reg;
    logic [NW-1:0] p2_num_reg [3];
    logic          p2_nneg_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_valid_reg <= 1'b0;
        else if (en)
            p2_valid_reg <= p1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_side_reg <= p1_side_reg;
            p2_den_reg  <= {p1_d_reg, 1'b0};
            p2_num_reg  <= p2_num_next;
            p2_nneg_reg <= p2_nneg_next;
        end
    end

    // divide
    logic          d_valid;
    side_t         d_side;
    logic [NW-1:0] d_q [3];
    logic          d_rnz [3];
    logic          d_neg [3];

    v3a_div_pipe #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p2_valid_reg),
        .in_side   (p2_side_reg),
        .in_num    (p2_num_reg),
        .in_neg    (p2_nneg_reg),
        .in_den    (p2_den_reg),
        .out_valid (d_valid),
        .out_side  (d_side),
        .out_q     (d_q),
        .out_rnz   (d_rnz),
        .out_neg   (d_neg)
    );

    // output stage: floor fix for negative numerators, saturate, select
    logic signed [NW+1:0] o_qs [3];
    satw_t                o_sw [3];
    logic signed [WORD_W-1:0] o_x_next;
    logic signed [WORD_W-1:0] o_y_next;
    logic signed [WORD_W-1:0] o_z_next;
    logic                     o_sat_next;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            o_qs[l] = $signed({2'b00, d_q[l]});
            if (d_neg[l])
                o_qs[l] = -(o_qs[l] + (NW+2)'(d_rnz[l]));
            o_sw[l] = sat_word(SAT_W'(o_qs[l]));
        end
        if (d_side.op == OP_DIV || d_side.op == OP_NORM)
        begin
            o_x_next   = o_sw[0].val;
            o_y_next   = o_sw[1].val;
            o_z_next   = o_sw[2].val;
            o_sat_next = o_sw[0].sat | o_sw[1].sat | o_sw[2].sat;
        end
        else
        begin
            o_x_next   = d_side.rx;
            o_y_next   = d_side.ry;
            o_z_next   = d_side.rz;
            o_sat_next = d_side.sat;
        end
    end

    logic                     o_valid_reg;
    logic signed [WORD_W-1:0] o_x_reg;
    logic signed [WORD_W-1:0] o_y_reg;
    logic signed [WORD_W-1:0] o_z_reg;
    logic                     o_sat_reg;

    assign en = !o_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (en)
            o_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg   <= o_x_next;
            o_y_reg   <= o_y_next;
            o_z_reg   <= o_z_next;
            o_sat_reg <= o_sat_next;
        end
    end

    assign req.ready     = en;
    assign rsp.valid     = o_valid_reg;
    assign rsp.res_x     = o_x_reg;
    assign rsp.res_y     = o_y_reg;
    assign rsp.res_z     = o_z_reg;
    assign rsp.saturated = o_sat_reg;

endmodule

/* sv/v3a_mul_stage.sv */
// v3a_mul_stage: operand routing and six registered 32x32 signed multipliers.
// Depends on v3a_pkg.
`timescale 1ns / 1ps

module v3a_mul_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  v3a_pkg::item_t     in_item,
    output logic               out_valid,
    output v3a_pkg::item_t     out_item,
    output logic signed [63:0] prod [6]
);
    import v3a_pkg::*;

    logic signed [WORD_W-1:0] opa [6];
    logic signed [WORD_W-1:0] opb [6];

    logic               valid_reg;
    item_t              item_reg;
    logic signed [63:0] prod_reg [6];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            opa[i] = '0;
            opb[i] = '0;
        end
        case (in_item.op)
            OP_MUL, OP_DOT:
            begin
                opa[0] = in_item.ax; opb[0] = in_item.bx;
                opa[1] = in_item.ay; opb[1] = in_item.by_comp;
                opa[2] = in_item.az; opb[2] = in_item.bz;
            end
            OP_SCALE:
            begin
                opa[0] = in_item.ax; opb[0] = in_item.k;
                opa[1] = in_item.ay; opb[1] = in_item.k;
                opa[2] = in_item.az; opb[2] = in_item.k;
            end
            OP_CROSS:
            begin
                opa[0] = in_item.ay; opb[0] = in_item.bz;
                opa[1] = in_item.az; opb[1] = in_item.bx;
                opa[2] = in_item.ax; opb[2] = in_item.by_comp;
                opa[3] = in_item.az; opb[3] = in_item.by_comp;
                opa[4] = in_item.ax; opb[4] = in_item.bz;
                opa[5] = in_item.ay; opb[5] = in_item.bx;
            end
            OP_MAG, OP_NORM:
            begin
                opa[0] = in_item.ax; opb[0] = in_item.ax;
                opa[1] = in_item.ay; opb[1] = in_item.ay;
                opa[2] = in_item.az; opb[2] = in_item.az;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            for (int i = 0; i < 6; i++)
                prod_reg[i] <= 64'(opa[i]) * 64'(opb[i]);
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign prod      = prod_reg;

endmodule

/* sv/v3a_sqrt_pipe.sv */
// v3a_sqrt_pipe: 32-stage integer square root, one result bit per stage.
// Depends on v3a_pkg. Gives floor root and remainder; caller rounds.
`timescale 1ns / 1ps

module v3a_sqrt_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  v3a_pkg::side_t             in_side,
    input  logic [v3a_pkg::SQ_W-1:0]   in_rad,
    output logic                       out_valid,
    output v3a_pkg::side_t             out_side,
    output logic [v3a_pkg::ROOT_W-1:0] out_root,
    output logic [v3a_pkg::REM_W-1:0]  out_rem
);
    import v3a_pkg::*;

    logic              valid_reg [ROOT_W];
    side_t             side_reg  [ROOT_W];
    logic [SQ_W-1:0]   rad_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_stage
        logic              cur_valid;
        side_t             cur_side;
        logic [SQ_W-1:0]   cur_rad;
        logic [ROOT_W-1:0] cur_root;
        logic [REM_W-1:0]  cur_rem;
        logic [REM_W+1:0]  rem2;
        logic [REM_W+1:0]  trial;
        logic [ROOT_W-1:0] root_next;
        logic [REM_W-1:0]  rem_next;

        if (g == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur_side  = in_side;
            assign cur_rad   = in_rad;
            assign cur_root  = '0;
            assign cur_rem   = '0;
        end
        else
        begin : g_next
            assign cur_valid = valid_reg[g-1];
            assign cur_side  = side_reg[g-1];
            assign cur_rad   = rad_reg[g-1];
            assign cur_root  = root_reg[g-1];
            assign cur_rem   = rem_reg[g-1];
        end

        always_comb
        begin
            rem2  = {cur_rem, cur_rad[SQ_W-1-2*g -: 2]};
            trial = (REM_W+2)'({cur_root, 2'b01});
            if (rem2 >= trial)
            begin
                rem_next  = REM_W'(rem2 - trial);
                root_next = {cur_root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem2);
                root_next = {cur_root[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= cur_side;
                rad_reg[g]  <= cur_rad;
                root_reg[g] <= root_next;
                rem_reg[g]  <= rem_next;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_rem   = rem_reg[ROOT_W-1];

endmodule

/* sv/v3a_div_pipe.sv */
// v3a_div_pipe: three-lane restoring divider, one quotient bit per stage.
// Depends on v3a_pkg. Lanes share the divisor.
`timescale 1ns / 1ps

module v3a_div_pipe #(
    parameter int NW = 49,
    parameter int DW = 34
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  v3a_pkg::side_t in_side,
    input  logic [NW-1:0]  in_num [3],
    input  logic           in_neg [3],
    input  logic [DW-1:0]  in_den,
    output logic           out_valid,
    output v3a_pkg::side_t out_side,
    output logic [NW-1:0]  out_q [3],
    output logic           out_rnz [3],
    output logic           out_neg [3]
);
    import v3a_pkg::*;

    logic          valid_reg [NW];
    side_t         side_reg  [NW];
    logic [DW-1:0] den_reg   [NW];
    logic [NW-1:0] num_reg   [NW][3];
    logic [NW-1:0] q_reg     [NW][3];
    logic [DW-1:0] rem_reg   [NW][3];
    logic          neg_reg   [NW][3];

    for (genvar g = 0; g < NW; g++)
    begin : g_stage
        logic          cur_valid;
        side_t         cur_side;
        logic [DW-1:0] cur_den;
        logic [NW-1:0] cur_num [3];
        logic [NW-1:0] cur_q   [3];
        logic [DW-1:0] cur_rem [3];
        logic          cur_neg [3];
        logic [DW:0]   trial   [3];
        logic [NW-1:0] q_next  [3];
        logic [DW-1:0] rem_next [3];

        if (g == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur_side  = in_side;
            assign cur_den   = in_den;
            assign cur_num   = in_num;
            assign cur_neg   = in_neg;
            assign cur_q     = '{default: '0};
            assign cur_rem   = '{default: '0};
        end
        else
        begin : g_next
            assign cur_valid = valid_reg[g-1];
            assign cur_side  = side_reg[g-1];
            assign cur_den   = den_reg[g-1];
            assign cur_num   = num_reg[g-1];
            assign cur_neg   = neg_reg[g-1];
            assign cur_q     = q_reg[g-1];
            assign cur_rem   = rem_reg[g-1];
        end

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {cur_rem[l], cur_num[l][NW-1-g]};
                if (trial[l] >= {1'b0, cur_den})
                begin
                    rem_next[l] = DW'(trial[l] - {1'b0, cur_den});
                    q_next[l]   = {cur_q[l][NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = DW'(trial[l]);
                    q_next[l]   = {cur_q[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g] <= cur_side;
                den_reg[g]  <= cur_den;
                num_reg[g]  <= cur_num;
                neg_reg[g]  <= cur_neg;
                q_reg[g]    <= q_next;
                rem_reg[g]  <= rem_next;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            out_q[l]   = q_reg[NW-1][l];
            out_rnz[l] = (rem_reg[NW-1][l] != '0);
            out_neg[l] = neg_reg[NW-1][l];
        end
    end

    assign out_valid = valid_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

/* sv/v3a_checker.sv */
// v3a_checker: port-level assertions for vec3_arith_unit_top, bound below.
// Depends on v3a_pkg for the word limits.
`timescale 1ns / 1ps

module v3a_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] res_x,
    input logic [31:0] res_y,
    input logic [31:0] res_z,
    input logic        saturated
);
    import v3a_pkg::*;

    // pipe advances exactly when the output word can move
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (!rsp_valid || rsp_ready))
        else $error("req.ready does not track output stall");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp.valid dropped while stalled");

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(res_x) && $stable(res_y)
                                    && $stable(res_z) && $stable(saturated))
        else $error("rsp word changed while stalled");

    // a clamped word has some component at a limit
    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && saturated |->
            res_x == WORD_MAX || res_x == WORD_MIN || res_y == WORD_MAX ||
            res_y == WORD_MIN || res_z == WORD_MAX || res_z == WORD_MIN)
        else $error("saturated set with no component at a limit");

endmodule

bind vec3_arith_unit_top v3a_checker u_v3a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .res_x     (rsp.res_x),
    .res_y     (rsp.res_y),
    .res_z     (rsp.res_z),
    .saturated (rsp.saturated)
);
